// File: sv/gsft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gsft_pkg;

   // Operation codes carried on the request tuser.
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_ERASE  = 3'd1;
   localparam logic [2:0] OP_MATCH  = 3'd2;
   localparam logic [2:0] OP_COUNT  = 3'd3;
   localparam logic [2:0] OP_LOOKUP = 3'd4;
   localparam logic [2:0] OP_CLEAR  = 3'd5;

   // Result status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   // The group count saturates at the top of its field.
   localparam logic [6:0] CNT_MAX = 7'd127;

   // One rule as it sits in the table memory.
   typedef struct packed {
      logic        valid;
      logic [7:0]  grp;
      logic [31:0] object_id;
      logic [31:0] net;
      logic [5:0]  prefix;
   } entry_type;

   // Per-entry compare results handed to the walk accumulators.
   typedef struct packed {
      logic free;
      logic obj_eq;
      logic grp_eq;
      logic net_hit;
   } eval_type;

endpackage

`default_nettype wire

// File: sv/gsft_rule_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module gsft_rule_eval
   import gsft_pkg::*;
(
   input  wire entry_type   entry,
   input  wire logic [7:0]  grp,
   input  wire logic [31:0] oid,
   input  wire logic [31:0] addr,
   output eval_type         result
);

   logic [31:0] mask;

   // Prefix mask: empty for length zero, full from 32 upward.
   always_comb begin
      if (entry.prefix == 6'd0) begin
         mask = '0;
      end else if (entry.prefix >= 6'd32) begin
         mask = '1;
      end else begin
         mask = 32'hffff_ffff << (6'd32 - entry.prefix);
      end
   end

   // The stored subnet is compared unmasked against the masked address.
   always_comb begin
      result.free    = !entry.valid;
      result.obj_eq  = entry.valid && (entry.object_id == oid);
      result.grp_eq  = entry.valid && (entry.grp == grp);
      result.net_hit = entry.valid && (entry.grp == grp) && ((addr & mask) == entry.net);
   end

endmodule

`default_nettype wire

// File: sv/grouped_subnet_filter_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Grouped IPv4 subnet filter table. Rules (group, object id, subnet, prefix
// length) live in one single-port-write, single-port-read table memory of
// CAPACITY entries with a registered read port. Each request beat carries
// one operation in req_tuser and returns exactly one response beat. Every
// operation except clear and an undefined code walks the whole memory one
// entry per cycle, then waits in a tail step for the last read, and the
// response step registers the response beat. The next request beat can be
// taken once the response step has passed. Clear sweeps the memory writing
// one entry per cycle and then presents its response. After reset the same
// sweep clears every entry before the first request beat is taken. An
// undefined operation skips the walk and answers with all fields zero. A
// finished response waits in the output register, and the next request
// beat can be accepted and walked meanwhile. One operation runs at a time;
// while the response is not taken the next finished operation holds in the
// response step and no new request beat is accepted.
module grouped_subnet_filter_table
   import gsft_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata from bit 0: group_id[7:0], object_id[31:0], subnet_ip[31:0],
   // prefix_len[5:0], address[31:0], two zero bits.
   input  wire logic [111:0] req_tdata,
   // tuser: op[2:0].
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata from bit 0: status[1:0], hit, group_count[6:0], found_ip[31:0],
   // found_prefix[5:0].
   output logic [47:0]       rsp_tdata
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SWEEP = 5'b00010,
      S_WALK  = 5'b00100,
      S_TAIL  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             sweep_rsp_ff, sweep_rsp_in;
   logic             req_fire, done_fire;

   // Latched request fields.
   logic [2:0]  op_ff;
   logic [7:0]  grp_ff;
   logic [31:0] oid_ff;
   logic [31:0] net_ff;
   logic [5:0]  plen_ff;
   logic [31:0] addr_ff;

   // Table memory and its ports.
   entry_type        rule_mem [CAPACITY];
   entry_type        rd_data_ff;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             mem_re, mem_we;
   logic [IDX_W-1:0] mem_wa;
   entry_type        mem_wd;

   // Walk accumulators.
   eval_type         ev;
   logic             obj_found_ff, obj_found_in;
   logic [IDX_W-1:0] obj_slot_ff, obj_slot_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_slot_ff, free_slot_in;
   logic             hit_ff, hit_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic [31:0]      fip_ff, fip_in;
   logic [5:0]       fpre_ff, fpre_in;

   // Response register and the fields that feed it.
   logic        rsp_tvalid_ff;
   logic [47:0] rsp_tdata_ff;
   logic [1:0]  res_status;
   logic        res_hit;
   logic [6:0]  res_count;
   logic [31:0] res_fip;
   logic [5:0]  res_fpre;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Capture the request beat.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_tuser;
         grp_ff  <= req_tdata[7:0];
         oid_ff  <= req_tdata[39:8];
         net_ff  <= req_tdata[71:40];
         plen_ff <= req_tdata[77:72];
         addr_ff <= req_tdata[109:78];
      end
   end

   // Sequencer: reset or clear sweep, walk, tail for the last read, then respond.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      sweep_rsp_in = sweep_rsp_ff;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = idx_ff;
      mem_wd       = '0;
      done_fire    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               idx_in       = '0;
               sweep_rsp_in = 1'b1;
               case (req_tuser)
                  OP_CLEAR:  state_in = S_SWEEP;
                  OP_INSERT: state_in = S_WALK;
                  OP_ERASE:  state_in = S_WALK;
                  OP_MATCH:  state_in = S_WALK;
                  OP_COUNT:  state_in = S_WALK;
                  OP_LOOKUP: state_in = S_WALK;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_SWEEP: begin
            mem_we = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = sweep_rsp_ff ? S_DONE : S_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_WALK: begin
            mem_re = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_TAIL;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_TAIL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               done_fire = 1'b1;
               state_in  = S_IDLE;
               mem_wd.valid     = 1'b1;
               mem_wd.grp       = grp_ff;
               mem_wd.object_id = oid_ff;
               mem_wd.net       = net_ff;
               mem_wd.prefix    = plen_ff;
               case (op_ff)
                  OP_INSERT: begin
                     if (obj_found_ff) begin
                        mem_we = 1'b1;
                        mem_wa = obj_slot_ff;
                     end else if (free_found_ff) begin
                        mem_we = 1'b1;
                        mem_wa = free_slot_ff;
                     end
                  end
                  OP_ERASE: begin
                     mem_wd = '0;
                     if (obj_found_ff) begin
                        mem_we = 1'b1;
                        mem_wa = obj_slot_ff;
                     end
                  end
                  default: begin
                     mem_we = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         idx_ff       <= '0;
         sweep_rsp_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         sweep_rsp_ff <= sweep_rsp_in;
         rd_vld_ff    <= mem_re;
      end
   end

   // Table memory: one write and one registered read per cycle. Writes only
   // happen in the sweep or the response step, never during a walk, so no forwarding path is needed.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         rule_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= rule_mem[idx_ff];
      end
      rd_idx_ff <= idx_ff;
   end

   gsft_rule_eval u_eval (
      .entry  (rd_data_ff),
      .grp    (grp_ff),
      .oid    (oid_ff),
      .addr   (addr_ff),
      .result (ev)
   );

   // Fold each returned entry into the walk results.
   always_comb begin
      obj_found_in  = obj_found_ff;
      obj_slot_in   = obj_slot_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      hit_in        = hit_ff;
      cnt_in        = cnt_ff;
      fip_in        = fip_ff;
      fpre_in       = fpre_ff;
      if (req_fire) begin
         obj_found_in  = 1'b0;
         obj_slot_in   = '0;
         free_found_in = 1'b0;
         free_slot_in  = '0;
         hit_in        = 1'b0;
         cnt_in        = '0;
         fip_in        = '0;
         fpre_in       = '0;
      end else if (rd_vld_ff) begin
         if (ev.free && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = rd_idx_ff;
         end
         if (ev.obj_eq && !obj_found_ff) begin
            obj_found_in = 1'b1;
            obj_slot_in  = rd_idx_ff;
            fip_in       = rd_data_ff.net;
            fpre_in      = rd_data_ff.prefix;
         end
         if (ev.net_hit) begin
            hit_in = 1'b1;
         end
         if (ev.grp_eq && (cnt_ff != CNT_MAX)) begin
            cnt_in = cnt_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obj_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         hit_ff        <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         obj_found_ff  <= obj_found_in;
         free_found_ff <= free_found_in;
         hit_ff        <= hit_in;
         cnt_ff        <= cnt_in;
      end
      obj_slot_ff  <= obj_slot_in;
      free_slot_ff <= free_slot_in;
      fip_ff       <= fip_in;
      fpre_ff      <= fpre_in;
   end

   // Select the response fields for the finished operation.
   always_comb begin
      res_status = ST_OK;
      res_hit    = 1'b0;
      res_count  = '0;
      res_fip    = '0;
      res_fpre   = '0;
      case (op_ff)
         OP_INSERT: begin
            if (!obj_found_ff && !free_found_ff) begin
               res_status = ST_FULL;
            end
         end
         OP_ERASE: begin
            if (!obj_found_ff) begin
               res_status = ST_NOT_FOUND;
            end
         end
         OP_MATCH: begin
            res_hit = hit_ff;
         end
         OP_COUNT: begin
            res_count = cnt_ff;
         end
         OP_LOOKUP: begin
            if (obj_found_ff) begin
               res_fip  = fip_ff;
               res_fpre = fpre_ff;
            end else begin
               res_status = ST_NOT_FOUND;
            end
         end
         default: begin
            res_status = ST_OK;
         end
      endcase
   end

   // Output register: holds the response beat until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (done_fire) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
      if (done_fire) begin
         rsp_tdata_ff <= {res_fpre, res_fip, res_count, res_hit, res_status};
      end
   end

`ifndef NO_ASSERTIONS
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_SWEEP || state_ff == S_DONE))
      else $error("Table written outside the sweep or the response step.");

   a_read_phase: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == S_WALK || state_ff == S_TAIL))
      else $error("Read data returned after the walk had ended.");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_DONE))
      else $error("Response raised without a finished operation.");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("Accepted request beat did not start an operation.");
`endif

endmodule

`default_nettype wire
